[rtl/core/npc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the near-plane triangle clipper.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = 8;
  localparam logic [30:0] NEAR_RESET = 31'd66;

  typedef logic [2:0][31:0] vtx_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_TWO,
    MODE_ALL
  } mode_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_a_z;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic signed [31:0] out_b_z;
    logic signed [31:0] out_c_x;
    logic signed [31:0] out_c_y;
    logic signed [31:0] out_c_z;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [32:0]      rem;
    logic [32:0]      den;
    logic [31:0]      q;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } lane_t;

  typedef struct packed {
    mode_t          mode;
    vtx_t           k0;
    vtx_t           k1;
    vtx_t           k2;
    lane_t [1:0]    lane;
  } item_t;

  typedef struct packed {
    mode_t mode;
    vtx_t  k0;
    vtx_t  k1;
    vtx_t  k2;
    vtx_t  x0;
    vtx_t  x1;
  } tri_set_t;

endpackage

[rtl/core/npc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_classify
// Classes the vertices against the near plane and sets up both edge lanes.
// ----------------------------------------------------------------------------
module npc_classify (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  npc_pkg::in_t   in_data,
  input  logic [30:0]    near_r,
  output logic           valid_r,
  output npc_pkg::item_t item_r
);

  npc_pkg::vtx_t  v [3];
  logic [2:0]     ins;
  logic [1:0]     ea0, eb0, ea1, eb1;
  npc_pkg::mode_t mode;
  npc_pkg::item_t item_nxt;

  function automatic npc_pkg::lane_t make_lane(npc_pkg::vtx_t va, npc_pkg::vtx_t vb,
                                               logic [30:0] nr);
    npc_pkg::lane_t l;
    logic [32:0]    d;
    l.den = {va[2][31], va[2]} - {vb[2][31], vb[2]};
    l.rem = {va[2][31], va[2]} - {2'b00, nr};
    l.q   = '0;
    for (int k = 0; k < 3; k++) begin
      d        = {vb[k][31], vb[k]} - {va[k][31], va[k]};
      l.neg[k] = d[32];
      l.mag[k] = d[32] ? 32'(-d) : d[31:0];
    end
    return l;
  endfunction

  always_comb begin
    v[0] = {in_data.a_z, in_data.a_y, in_data.a_x};
    v[1] = {in_data.b_z, in_data.b_y, in_data.b_x};
    v[2] = {in_data.c_z, in_data.c_y, in_data.c_x};
    for (int i = 0; i < 3; i++) begin
      ins[i] = $signed(v[i][2]) >= $signed({1'b0, near_r});
    end
    ea0 = 2'd0;
    eb0 = 2'd1;
    ea1 = 2'd1;
    eb1 = 2'd2;
    case (ins)
      3'b000: mode = npc_pkg::MODE_NONE;
      3'b111: mode = npc_pkg::MODE_ALL;
      3'b001: begin
        mode = npc_pkg::MODE_ONE;
        ea0 = 2'd0; eb0 = 2'd1; ea1 = 2'd0; eb1 = 2'd2;
      end
      3'b010: begin
        mode = npc_pkg::MODE_ONE;
        ea0 = 2'd1; eb0 = 2'd0; ea1 = 2'd1; eb1 = 2'd2;
      end
      3'b100: begin
        mode = npc_pkg::MODE_ONE;
        ea0 = 2'd2; eb0 = 2'd0; ea1 = 2'd2; eb1 = 2'd1;
      end
      3'b011: begin
        mode = npc_pkg::MODE_TWO;
        ea0 = 2'd0; eb0 = 2'd2; ea1 = 2'd1; eb1 = 2'd2;
      end
      3'b101: begin
        mode = npc_pkg::MODE_TWO;
        ea0 = 2'd0; eb0 = 2'd1; ea1 = 2'd2; eb1 = 2'd1;
      end
      3'b110: begin
        mode = npc_pkg::MODE_TWO;
        ea0 = 2'd1; eb0 = 2'd0; ea1 = 2'd2; eb1 = 2'd0;
      end
      default: mode = npc_pkg::MODE_NONE;
    endcase
    item_nxt.mode    = mode;
    item_nxt.k0      = v[ea0];
    item_nxt.k1      = v[ea1];
    item_nxt.k2      = v[2];
    item_nxt.lane[0] = make_lane(v[ea0], v[eb0], near_r);
    item_nxt.lane[1] = make_lane(v[ea1], v[eb1], near_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/core/npc_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_div_stage
// One stage of the restoring divider that forms the edge ratio of both lanes.
// ----------------------------------------------------------------------------
module npc_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_in,
  input  npc_pkg::item_t item_in,
  output logic           valid_r,
  output npc_pkg::item_t item_r
);

  npc_pkg::item_t item_nxt;
  logic [33:0]    r2;

  always_comb begin
    item_nxt = item_in;
    r2       = '0;
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < int'(npc_pkg::DIV_STEPS); s++) begin
        r2 = {item_nxt.lane[l].rem, 1'b0};
        if (r2 >= {1'b0, item_nxt.lane[l].den}) begin
          r2 = r2 - {1'b0, item_nxt.lane[l].den};
          item_nxt.lane[l].q = {item_nxt.lane[l].q[30:0], 1'b1};
        end else begin
          item_nxt.lane[l].q = {item_nxt.lane[l].q[30:0], 1'b0};
        end
        item_nxt.lane[l].rem = r2[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/core/npc_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_lerp
// Two-stage interpolation of both edge intersections: multiply, then round
// and apply the sign.
// ----------------------------------------------------------------------------
module npc_lerp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  npc_pkg::item_t   item_in,
  output logic             valid_r,
  output npc_pkg::tri_set_t set_r
);

  logic                  m_valid_r;
  npc_pkg::mode_t        m_mode_r;
  npc_pkg::vtx_t         m_k0_r, m_k1_r, m_k2_r;
  logic [1:0][2:0]       m_neg_r;
  logic [1:0][2:0][62:0] m_prod_r;
  logic [1:0][2:0][62:0] m_prod_nxt;
  logic [30:0]           t [2];
  npc_pkg::vtx_t         x_nxt [2];
  npc_pkg::vtx_t         pa [2];
  logic [63:0]           sum;
  logic [32:0]           q, res;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l] = item_in.lane[l].q[31:1];
      for (int k = 0; k < 3; k++) begin
        m_prod_nxt[l][k] = {31'b0, item_in.lane[l].mag[k]} * {32'b0, t[l]};
      end
    end
  end

  always_comb begin
    pa[0] = m_k0_r;
    pa[1] = m_k1_r;
    sum   = '0;
    q     = '0;
    res   = '0;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        sum = {1'b0, m_prod_r[l][k]} + 64'h0000_0000_4000_0000;
        q   = sum[63:31];
        res = m_neg_r[l][k] ? {pa[l][k][31], pa[l][k]} - q : {pa[l][k][31], pa[l][k]} + q;
        x_nxt[l][k] = res[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      valid_r   <= 1'b0;
    end else if (en) begin
      m_valid_r <= valid_in;
      valid_r   <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_mode_r <= item_in.mode;
      m_k0_r   <= item_in.k0;
      m_k1_r   <= item_in.k1;
      m_k2_r   <= item_in.k2;
      m_neg_r  <= {item_in.lane[1].neg, item_in.lane[0].neg};
      m_prod_r <= m_prod_nxt;
      set_r.mode <= m_mode_r;
      set_r.k0   <= m_k0_r;
      set_r.k1   <= m_k1_r;
      set_r.k2   <= m_k2_r;
      set_r.x0   <= x_nxt[0];
      set_r.x1   <= x_nxt[1];
    end
  end

endmodule

[rtl/core/npc_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_emit
// Output register that sends the one or two triangles of each clipped input.
// ----------------------------------------------------------------------------
module npc_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              set_valid,
  input  npc_pkg::tri_set_t set_in,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output npc_pkg::out_t     out_data
);

  logic          valid_r, valid_nxt;
  logic          two_r, two_nxt;
  logic          phase_r, phase_nxt;
  npc_pkg::vtx_t t0a_r, t0b_r, t0c_r, t1a_r, t1b_r, t1c_r;
  npc_pkg::vtx_t va, vb, vc;
  logic          last;

  assign last = !two_r || phase_r;
  assign take = !valid_r || (!out_stall && last);

  always_comb begin
    valid_nxt = valid_r;
    two_nxt   = two_r;
    phase_nxt = phase_r;
    if (take) begin
      valid_nxt = set_valid && (set_in.mode != npc_pkg::MODE_NONE);
      two_nxt   = set_in.mode == npc_pkg::MODE_TWO;
      phase_nxt = 1'b0;
    end else if (!out_stall) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      two_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      two_r   <= two_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t0a_r <= set_in.k0;
      t1a_r <= set_in.k1;
      t1b_r <= set_in.x1;
      t1c_r <= set_in.x0;
      case (set_in.mode)
        npc_pkg::MODE_ALL: begin
          t0b_r <= set_in.k1;
          t0c_r <= set_in.k2;
        end
        npc_pkg::MODE_ONE: begin
          t0b_r <= set_in.x0;
          t0c_r <= set_in.x1;
        end
        default: begin
          t0b_r <= set_in.k1;
          t0c_r <= set_in.x0;
        end
      endcase
    end
  end

  always_comb begin
    va = phase_r ? t1a_r : t0a_r;
    vb = phase_r ? t1b_r : t0b_r;
    vc = phase_r ? t1c_r : t0c_r;
    out_data.out_a_x     = va[0];
    out_data.out_a_y     = va[1];
    out_data.out_a_z     = va[2];
    out_data.out_b_x     = vb[0];
    out_data.out_b_y     = vb[1];
    out_data.out_b_z     = vb[2];
    out_data.out_c_x     = vc[0];
    out_data.out_c_y     = vc[1];
    out_data.out_c_z     = vc[2];
    out_data.last_of_run = last;
  end

  assign out_valid = valid_r;

endmodule

[rtl/core/near_plane_triangle_clipper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper_top
// Clips a Q16.16 camera-space triangle against the near plane z = near.
// ----------------------------------------------------------------------------
// Usage: a triangle request enters on in_valid/in_stall/in_data and is taken
// at an edge where in_valid is high and in_stall low. Each request yields
// zero, one or two triangles on out_valid/out_stall/out_data; last_of_run
// marks the final one of a request.
// A request can be taken every cycle while in_stall is low. A request that
// makes two triangles holds the output while both go out, and the input may
// wait meanwhile. The first triangle passes one setup stage, eight stages of
// the ratio divider at four quotient bits each, two interpolation stages and
// the output register.
// The near plane register is written through cfg_we/cfg_wdata and resets to
// 66. Reset empties the pipeline.
// While the receiver stalls, the pipeline moves on until a finished request
// waits behind the output register; then it holds and in_stall rises.
// ----------------------------------------------------------------------------
module near_plane_triangle_clipper_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  npc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output npc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [30:0]   cfg_wdata
);

  logic [30:0]       near_r;
  logic              en, take;
  logic              div_valid [npc_pkg::DIV_STAGES + 1];
  npc_pkg::item_t    div_item  [npc_pkg::DIV_STAGES + 1];
  logic              lerp_valid;
  npc_pkg::tri_set_t lerp_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= npc_pkg::NEAR_RESET;
    end else if (cfg_we) begin
      near_r <= cfg_wdata;
    end
  end

  assign en       = !lerp_valid || take;
  assign in_stall = !en;

  npc_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .near_r   (near_r),
    .valid_r  (div_valid[0]),
    .item_r   (div_item[0])
  );

  for (genvar g = 0; g < int'(npc_pkg::DIV_STAGES); g++) begin : g_div
    npc_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (div_valid[g]),
      .item_in  (div_item[g]),
      .valid_r  (div_valid[g+1]),
      .item_r   (div_item[g+1])
    );
  end

  npc_lerp u_lerp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (div_valid[npc_pkg::DIV_STAGES]),
    .item_in  (div_item[npc_pkg::DIV_STAGES]),
    .valid_r  (lerp_valid),
    .set_r    (lerp_set)
  );

  npc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (lerp_valid),
    .set_in    (lerp_set),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_run) |=>
      (out_valid && out_data.last_of_run))
    else $error("second triangle of a pair did not follow");

  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    (lerp_valid && !take) |-> in_stall)
    else $error("input taken while the pipeline is blocked");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(div_item[0]) && $stable(lerp_set) && $stable(lerp_valid)))
    else $error("pipeline moved while stalled");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (near_r == $past(cfg_wdata)))
    else $error("near plane write lost");

endmodule
